>>> design/srclx_pkg.sv
// srclx_pkg: types, codes and byte-class functions for the source lexer.
// No dependencies; imported by source_lexer, srclx_chk and tb_top.
package srclx_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_START_LINE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_COLUMN = 1'b1;

  // Token kinds
  localparam logic [2:0] KIND_SYMBOL     = 3'd0;
  localparam logic [2:0] KIND_KEYWORD_FN = 3'd1;
  localparam logic [2:0] KIND_INT        = 3'd2;
  localparam logic [2:0] KIND_FLOAT      = 3'd3;
  localparam logic [2:0] KIND_OPERATOR   = 3'd4;
  localparam logic [2:0] KIND_DELIMITER  = 3'd5;
  localparam logic [2:0] KIND_UNEXPECTED = 3'd6;
  localparam logic [2:0] KIND_EOF        = 3'd7;

  localparam logic [4:0] OP_SUB_MAX    = 5'd19;
  localparam logic [4:0] DELIM_SUB_MAX = 5'd6;

  // Keyword match progress for "fn"
  localparam logic [1:0] KW_NONE = 2'd0;
  localparam logic [1:0] KW_F    = 2'd1;
  localparam logic [1:0] KW_FN   = 2'd2;

  // Operator table: index of the first character, second character is '='
  // except for the two logical pairs.
  localparam logic [3:0] OP_BIT_AND = 4'd8;
  localparam logic [3:0] OP_BIT_OR  = 4'd9;
  localparam logic [3:0] OP_COUNT   = 4'd10;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;

  // Output queue depth
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SYMBOL,
    MODE_NUMBER,
    MODE_OPERATOR
  } mode_t;

  // One result token as it sits in the output queue
  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  sub;
    logic [7:0]  bad;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] end_col;
    logic        last;
  } res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // First character of an operator: {hit, index}
  function automatic logic [4:0] op_first(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      8'h2B:   r = {1'b1, 4'd0};   // +
      8'h2D:   r = {1'b1, 4'd1};   // -
      8'h2A:   r = {1'b1, 4'd2};   // *
      8'h2F:   r = {1'b1, 4'd3};   // /
      CH_EQ:   r = {1'b1, 4'd4};
      8'h21:   r = {1'b1, 4'd5};   // !
      8'h3C:   r = {1'b1, 4'd6};   // <
      8'h3E:   r = {1'b1, 4'd7};   // >
      CH_AMP:  r = {1'b1, OP_BIT_AND};
      CH_BAR:  r = {1'b1, OP_BIT_OR};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] op_second(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      OP_BIT_AND: r = CH_AMP;
      OP_BIT_OR:  r = CH_BAR;
      default:    r = CH_EQ;
    endcase
    return r;
  endfunction

  // Delimiter: {hit, index}
  function automatic logic [3:0] delim(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      8'h28:   r = {1'b1, 3'd0};   // (
      8'h29:   r = {1'b1, 3'd1};   // )
      8'h7B:   r = {1'b1, 3'd2};   // {
      8'h7D:   r = {1'b1, 3'd3};   // }
      8'h5B:   r = {1'b1, 3'd4};   // [
      8'h5D:   r = {1'b1, 3'd5};   // ]
      8'h2C:   r = {1'b1, 3'd6};   // ,
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] clamp16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [4:0] sub,
                                  input logic [7:0] bad, input logic [31:0] line,
                                  input logic [31:0] col, input logic [31:0] end_col);
    res_t r;
    r.kind    = kind;
    r.sub     = sub;
    r.bad     = bad;
    r.line    = clamp16(line);
    r.col     = clamp16(col);
    r.end_col = clamp16(end_col);
    r.last    = 1'b0;
    return r;
  endfunction

endpackage

>>> design/source_lexer.sv
// source_lexer: byte-at-a-time lexer with line/column tracking.
// Depends on srclx_pkg.
//
// One source byte enters per request; a zero byte ends the source. Each byte
// is taken into an input register, then one pass of classification logic
// updates the scanner state and pushes zero, one or two tokens into a
// four-entry output queue; tokens reach the outputs only from the queue head,
// never straight from the scanner. A byte is processed in any cycle
// where the queue has at least two free entries, so the block sustains one
// byte per cycle as long as the result side takes a token each cycle; the
// single output port (one token per cycle) sets the rate when bytes close
// two tokens at once. Positions are held at POSITION_BITS bits and saturate;
// reported positions saturate at 65535. start_line and start_column are
// sampled at the first byte of each source.
module source_lexer #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [srclx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata,
  // byte input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_source_char,
  // token output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_token_kind,
  output logic [4:0]                     out_sub_kind,
  output logic [7:0]                     out_bad_char,
  output logic [15:0]                    out_start_line_res,
  output logic [15:0]                    out_start_column_res,
  output logic [15:0]                    out_end_column,
  output logic                           out_last_of_run
);
  import srclx_pkg::*;

  localparam int unsigned PB = POSITION_BITS;
  localparam logic [31:0] POS_MAX32 = 32'((64'd1 << PB) - 64'd1);
  localparam logic [PB-1:0] POS_MAX = '1;

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (v == POS_MAX) ? v : v + PB'(1);
  endfunction

  function automatic logic [PB-1:0] clamp_reg(input logic [15:0] v);
    return (32'(v) > POS_MAX32) ? POS_MAX : PB'(v);
  endfunction

  // configuration registers
  logic [15:0] start_line_r, start_column_r;

  // input register
  logic       in_vld_r;
  logic [7:0] in_char_r;
  logic       in_accept;
  logic       go;

  // scanner state
  mode_t          mode_r, mode_nxt;
  logic [3:0]     pend_op_r, pend_op_nxt;
  logic [PB-1:0]  tok_line_r, tok_line_nxt;
  logic [PB-1:0]  tok_col_r, tok_col_nxt;
  logic [PB-1:0]  cur_line_r, cur_line_nxt;
  logic [PB-1:0]  cur_col_r, cur_col_nxt;
  logic           dot_r, dot_nxt;
  logic [1:0]     kw_r, kw_nxt;
  logic           fresh_r, fresh_nxt;

  // per-byte results
  res_t       res0, res1, res_idle;
  logic [1:0] n_res;
  logic       cont, emit_idle;
  logic [3:0] op_p;
  logic [4:0] op_hit;
  logic [3:0] dl_hit;
  logic [7:0] c;

  // output queue
  res_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              pop;
  logic [1:0]        n_go;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_line_r   <= '0;
      start_column_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_LINE:   start_line_r   <= cfg_wdata;
        REG_START_COLUMN: start_column_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register: refills when empty or being consumed
  assign go        = in_vld_r && (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_stall  = in_vld_r && !go;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_accept) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_char_r <= in_source_char;
    end
  end

  // scanner: next state and emitted tokens for the held byte
  assign c      = in_char_r;
  assign op_hit = op_first(c);
  assign dl_hit = delim(c);

  always_comb begin
    mode_nxt     = mode_r;
    pend_op_nxt  = pend_op_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    dot_nxt      = dot_r;
    kw_nxt       = kw_r;
    fresh_nxt    = 1'b0;
    cur_line_nxt = fresh_r ? clamp_reg(start_line_r)   : cur_line_r;
    cur_col_nxt  = fresh_r ? clamp_reg(start_column_r) : cur_col_r;
    res0         = '0;
    res1         = '0;
    res_idle     = '0;
    n_res        = 2'd0;
    cont         = 1'b1;
    emit_idle    = 1'b0;
    op_p         = (pend_op_r < OP_COUNT) ? pend_op_r : 4'd0;

    // finish or extend a held token
    unique case (mode_r)
      MODE_SYMBOL: begin
        if (is_letter(c) || is_digit(c)) begin
          kw_nxt      = (kw_r == KW_F && c == CH_N) ? KW_FN : KW_NONE;
          cur_col_nxt = sat_inc(cur_col_nxt);
          cont        = 1'b0;
        end else begin
          res0 = mk_res((kw_r == KW_FN) ? KIND_KEYWORD_FN : KIND_SYMBOL, 5'd0, 8'd0,
                        32'(tok_line_r), 32'(tok_col_r), 32'(cur_col_nxt));
          n_res    = 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c) || c == CH_DOT) begin
          if (c == CH_DOT) begin
            dot_nxt = 1'b1;
          end
          cur_col_nxt = sat_inc(cur_col_nxt);
          cont        = 1'b0;
        end else begin
          res0 = mk_res(dot_r ? KIND_FLOAT : KIND_INT, 5'd0, 8'd0,
                        32'(tok_line_r), 32'(tok_col_r), 32'(cur_col_nxt));
          n_res    = 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_OPERATOR: begin
        mode_nxt = MODE_IDLE;
        if (c == op_second(op_p)) begin
          cur_col_nxt = sat_inc(cur_col_nxt);
          res0 = mk_res(KIND_OPERATOR, {op_p, 1'b1}, 8'd0,
                        32'(tok_line_r), 32'(tok_col_r), 32'(cur_col_nxt));
          n_res = 2'd1;
          cont  = 1'b0;
        end else begin
          res0 = mk_res(KIND_OPERATOR, {op_p, 1'b0}, 8'd0,
                        32'(tok_line_r), 32'(tok_col_r), 32'(cur_col_nxt));
          n_res = 2'd1;
        end
      end
      default: ;
    endcase

    // byte seen from the idle state
    if (cont) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        cur_col_nxt = sat_inc(cur_col_nxt);
      end else if (c == CH_LF) begin
        cur_line_nxt = sat_inc(cur_line_nxt);
        cur_col_nxt  = '0;
      end else if (c == CH_NUL) begin
        res_idle = mk_res(KIND_EOF, 5'd0, 8'd0, 32'(cur_line_nxt),
                          32'(cur_col_nxt), 32'(cur_col_nxt));
        emit_idle    = 1'b1;
        mode_nxt     = MODE_IDLE;
        pend_op_nxt  = '0;
        tok_line_nxt = '0;
        tok_col_nxt  = '0;
        dot_nxt      = 1'b0;
        kw_nxt       = KW_NONE;
        fresh_nxt    = 1'b1;
      end else if (is_letter(c) || is_digit(c) || c == CH_DOT) begin
        tok_line_nxt = cur_line_nxt;
        tok_col_nxt  = cur_col_nxt;
        if (is_letter(c)) begin
          mode_nxt = MODE_SYMBOL;
          kw_nxt   = (c == CH_F) ? KW_F : KW_NONE;
        end else begin
          mode_nxt = MODE_NUMBER;
          dot_nxt  = (c == CH_DOT);
        end
        cur_col_nxt = sat_inc(cur_col_nxt);
      end else if (op_hit[4]) begin
        mode_nxt     = MODE_OPERATOR;
        pend_op_nxt  = op_hit[3:0];
        tok_line_nxt = cur_line_nxt;
        tok_col_nxt  = cur_col_nxt;
        cur_col_nxt  = sat_inc(cur_col_nxt);
      end else if (dl_hit[3]) begin
        res_idle = mk_res(KIND_DELIMITER, 5'(dl_hit[2:0]), 8'd0, 32'(cur_line_nxt),
                          32'(cur_col_nxt), 32'(sat_inc(cur_col_nxt)));
        emit_idle   = 1'b1;
        cur_col_nxt = sat_inc(cur_col_nxt);
      end else begin
        res_idle = mk_res(KIND_UNEXPECTED, 5'd0, c, 32'(cur_line_nxt),
                          32'(cur_col_nxt), 32'(cur_col_nxt));
        emit_idle   = 1'b1;
        cur_col_nxt = sat_inc(cur_col_nxt);
      end
    end

    // place the idle-state token after any flushed one
    if (emit_idle) begin
      if (n_res == 2'd0) begin
        res0 = res_idle;
      end else begin
        res1 = res_idle;
      end
      n_res = n_res + 2'd1;
    end

    // mark the last token of this byte
    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      pend_op_r  <= '0;
      tok_line_r <= '0;
      tok_col_r  <= '0;
      cur_line_r <= '0;
      cur_col_r  <= '0;
      dot_r      <= 1'b0;
      kw_r       <= KW_NONE;
      fresh_r    <= 1'b1;
    end else if (go) begin
      mode_r     <= mode_nxt;
      pend_op_r  <= pend_op_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      dot_r      <= dot_nxt;
      kw_r       <= kw_nxt;
      fresh_r    <= fresh_nxt;
    end
  end

  // output queue
  assign n_go = go ? n_res : 2'd0;
  assign pop  = (cnt_r != '0) && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(n_go);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(pop);
      cnt_r    <= cnt_r + QCNT_W'(n_go) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_go != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (n_go == 2'd2) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= res1;
    end
  end

  // queue head drives the result port
  assign out_valid            = (cnt_r != '0);
  assign out_token_kind       = q_r[rd_ptr_r].kind;
  assign out_sub_kind         = q_r[rd_ptr_r].sub;
  assign out_bad_char         = q_r[rd_ptr_r].bad;
  assign out_start_line_res   = q_r[rd_ptr_r].line;
  assign out_start_column_res = q_r[rd_ptr_r].col;
  assign out_end_column       = q_r[rd_ptr_r].end_col;
  assign out_last_of_run      = q_r[rd_ptr_r].last;

endmodule

>>> design/srclx_chk.sv
// srclx_chk: port-level checks on the source lexer's token stream.
// Depends on srclx_pkg; bound to source_lexer at the end of this file.
module srclx_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_token_kind,
  input logic [4:0]  out_sub_kind,
  input logic [7:0]  out_bad_char,
  input logic [15:0] out_start_column_res,
  input logic [15:0] out_end_column,
  input logic        out_last_of_run
);
  import srclx_pkg::*;

  // a stalled token stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("token dropped while stalled");

  // end of file closes the byte's run with an empty span and no extras
  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_EOF |->
      out_last_of_run && out_sub_kind == 5'd0 && out_bad_char == 8'd0 &&
      out_end_column == out_start_column_res)
    else $error("malformed end-of-file token");

  // error tokens have an empty span
  a_bad_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_UNEXPECTED |->
      out_end_column == out_start_column_res && out_sub_kind == 5'd0)
    else $error("unexpected-char token with nonempty span");

  // only error tokens carry a byte
  a_bad_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_UNEXPECTED |-> out_bad_char == 8'd0)
    else $error("bad_char set on a regular token");

  // subkind stays in range for its kind
  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_token_kind == KIND_OPERATOR && out_sub_kind <= OP_SUB_MAX) ||
      (out_token_kind == KIND_DELIMITER && out_sub_kind <= DELIM_SUB_MAX) ||
      (out_token_kind != KIND_OPERATOR && out_token_kind != KIND_DELIMITER &&
       out_sub_kind == 5'd0))
    else $error("sub_kind out of range");

endmodule

bind source_lexer srclx_chk u_srclx_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_token_kind       (out_token_kind),
  .out_sub_kind         (out_sub_kind),
  .out_bad_char         (out_bad_char),
  .out_start_column_res (out_start_column_res),
  .out_end_column       (out_end_column),
  .out_last_of_run      (out_last_of_run)
);

>>> dv/tb_top.sv
// tb_top: self-checking testbench for source_lexer (byte stream in, tokens out).
// Depends on srclx_pkg and source_lexer; holds its own lexer model, stimulus and checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import srclx_pkg::*;

  localparam int     RESET_CYCLES = 11;
  localparam longint CYCLE_LIMIT  = 1_000_000;
  localparam int     SETTLE_LEN   = 8;     // cycles for an in-flight byte to clear the pipe
  localparam int     MAX_PRINTED  = 40;
  localparam int     PHASE_ITEMS  = 300;   // bytes per random phase (six phases)
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  sub;
    logic [7:0]  bad;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] end_col;
    logic        last;
  } token_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_source_char;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           out_token_kind;
  logic [4:0]           out_sub_kind;
  logic [7:0]           out_bad_char;
  logic [15:0]          out_start_line_res;
  logic [15:0]          out_start_column_res;
  logic [15:0]          out_end_column;
  logic                 out_last_of_run;

  // lexer model state
  mode_t       lex_mode;
  logic [3:0]  held_op;
  logic [15:0] tok_line, tok_col;
  logic [15:0] cur_line, cur_col;
  logic [15:0] base_line, base_col;
  logic        frac_seen;
  logic [1:0]  fn_match;
  bit          at_source_start;

  token_t  expected_tokens[$];
  int      n_errors;
  int      bytes_sent;
  longint  n_cycles;
  int      gap_pct;
  int      stall_pct;
  int      hold_req;
  int      hold_left;
  int      burst_left;

  always #4 clk = ~clk;

  source_lexer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_source_char      (in_source_char),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_kind      (out_token_kind),
    .out_sub_kind        (out_sub_kind),
    .out_bad_char        (out_bad_char),
    .out_start_line_res  (out_start_line_res),
    .out_start_column_res(out_start_column_res),
    .out_end_column      (out_end_column),
    .out_last_of_run     (out_last_of_run)
  );

  // ---------------------------------------------------------------- byte classes
  function automatic bit alpha_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic bit digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // operator lead characters, in sub_kind order (sub = 2*index, +1 for the pair)
  function automatic logic [7:0] op_char(input int i);
    case (i)
      0:       return "+";
      1:       return "-";
      2:       return "*";
      3:       return "/";
      4:       return CH_EQ;
      5:       return "!";
      6:       return "<";
      7:       return ">";
      8:       return CH_AMP;
      default: return CH_BAR;
    endcase
  endfunction

  function automatic logic [7:0] op_follow(input int i);
    if (i == OP_BIT_AND) return CH_AMP;
    if (i == OP_BIT_OR)  return CH_BAR;
    return CH_EQ;
  endfunction

  function automatic logic [7:0] delim_char(input int i);
    case (i)
      0:       return "(";
      1:       return ")";
      2:       return "{";
      3:       return "}";
      4:       return "[";
      5:       return "]";
      default: return ",";
    endcase
  endfunction

  function automatic int op_index(input logic [7:0] c);
    for (int i = 0; i < OP_COUNT; i++)
      if (op_char(i) == c) return i;
    return -1;
  endfunction

  function automatic int delim_index(input logic [7:0] c);
    for (int i = 0; i <= DELIM_SUB_MAX; i++)
      if (delim_char(i) == c) return i;
    return -1;
  endfunction

  // ---------------------------------------------------------------- lexer model
  function automatic logic [15:0] step_pos(input logic [15:0] p);
    return (p == 16'hFFFF) ? p : p + 16'd1;
  endfunction

  function automatic token_t make_token(input logic [2:0] kind, input logic [4:0] sub,
                                        input logic [7:0] bad, input logic [15:0] line,
                                        input logic [15:0] col, input logic [15:0] end_col);
    token_t t;
    t.kind    = kind;
    t.sub     = sub;
    t.bad     = bad;
    t.line    = line;
    t.col     = col;
    t.end_col = end_col;
    t.last    = 1'b0;
    return t;
  endfunction

  task automatic clear_lexer_state();
    lex_mode        = MODE_IDLE;
    held_op         = '0;
    tok_line        = '0;
    tok_col         = '0;
    frac_seen       = 1'b0;
    fn_match        = KW_NONE;
    at_source_start = 1'b1;
  endtask

  // Advance the model by one accepted byte and queue the tokens it closes.
  task automatic lex_byte(input logic [7:0] c);
    token_t      toks[$];
    bit          absorbed;
    int          op_i;
    int          dl_i;
    logic [15:0] nxt;
    absorbed = 1'b0;
    op_i     = op_index(c);
    dl_i     = delim_index(c);
    if (at_source_start) begin
      cur_line        = base_line;
      cur_col         = base_col;
      at_source_start = 1'b0;
    end

    // a held token either grows or is closed by this byte
    case (lex_mode)
      MODE_SYMBOL: begin
        if (alpha_byte(c) || digit_byte(c)) begin
          fn_match = (fn_match == KW_F && c == CH_N) ? KW_FN : KW_NONE;
          cur_col  = step_pos(cur_col);
          absorbed = 1'b1;
        end else begin
          toks.push_back(make_token((fn_match == KW_FN) ? KIND_KEYWORD_FN : KIND_SYMBOL,
                                    '0, '0, tok_line, tok_col, cur_col));
          lex_mode = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (digit_byte(c) || c == CH_DOT) begin
          if (c == CH_DOT) frac_seen = 1'b1;
          cur_col  = step_pos(cur_col);
          absorbed = 1'b1;
        end else begin
          toks.push_back(make_token(frac_seen ? KIND_FLOAT : KIND_INT,
                                    '0, '0, tok_line, tok_col, cur_col));
          lex_mode = MODE_IDLE;
        end
      end
      MODE_OPERATOR: begin
        lex_mode = MODE_IDLE;
        if (c == op_follow(int'(held_op))) begin
          cur_col = step_pos(cur_col);
          toks.push_back(make_token(KIND_OPERATOR, {held_op, 1'b1}, '0,
                                    tok_line, tok_col, cur_col));
          absorbed = 1'b1;
        end else begin
          toks.push_back(make_token(KIND_OPERATOR, {held_op, 1'b0}, '0,
                                    tok_line, tok_col, cur_col));
        end
      end
      default: ;
    endcase

    // the byte itself, seen from idle
    if (!absorbed) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        cur_col = step_pos(cur_col);
      end else if (c == CH_LF) begin
        cur_line = step_pos(cur_line);
        cur_col  = '0;
      end else if (c == CH_NUL) begin
        toks.push_back(make_token(KIND_EOF, '0, '0, cur_line, cur_col, cur_col));
        clear_lexer_state();
      end else if (alpha_byte(c) || digit_byte(c) || c == CH_DOT) begin
        tok_line = cur_line;
        tok_col  = cur_col;
        if (alpha_byte(c)) begin
          lex_mode = MODE_SYMBOL;
          fn_match = (c == CH_F) ? KW_F : KW_NONE;
        end else begin
          lex_mode  = MODE_NUMBER;
          frac_seen = (c == CH_DOT);
        end
        cur_col = step_pos(cur_col);
      end else if (op_i >= 0) begin
        lex_mode = MODE_OPERATOR;
        held_op  = op_i[3:0];
        tok_line = cur_line;
        tok_col  = cur_col;
        cur_col  = step_pos(cur_col);
      end else if (dl_i >= 0) begin
        nxt = step_pos(cur_col);
        toks.push_back(make_token(KIND_DELIMITER, dl_i[4:0], '0, cur_line, cur_col, nxt));
        cur_col = nxt;
      end else begin
        toks.push_back(make_token(KIND_UNEXPECTED, '0, c, cur_line, cur_col, cur_col));
        cur_col = step_pos(cur_col);
      end
    end

    if (toks.size() > 0) toks[toks.size()-1].last = 1'b1;
    foreach (toks[i]) expected_tokens.push_back(toks[i]);
  endtask

  // ---------------------------------------------------------------- reporting
  task automatic report_error(input string msg);
    if (n_errors < MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // result checker: every accepted token against the oldest expected one
  always @(posedge clk) begin : token_check
    token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_error($sformatf("unexpected token kind %0d at %0d:%0d",
                               out_token_kind, out_start_line_res, out_start_column_res));
      end else begin
        want = expected_tokens.pop_front();
        if (out_token_kind !== want.kind || out_sub_kind !== want.sub ||
            out_bad_char !== want.bad || out_start_line_res !== want.line ||
            out_start_column_res !== want.col || out_end_column !== want.end_col ||
            out_last_of_run !== want.last)
          report_error($sformatf(
            "got k%0d s%0d b%02h %0d:%0d-%0d l%0d, want k%0d s%0d b%02h %0d:%0d-%0d l%0d",
            out_token_kind, out_sub_kind, out_bad_char, out_start_line_res,
            out_start_column_res, out_end_column, out_last_of_run,
            want.kind, want.sub, want.bad, want.line, want.col, want.end_col, want.last));
      end
    end
  end

  // result side stall: random bursts, plus a long counted hold-off on request
  always @(posedge clk) begin : result_stall
    bit stall_now;
    int r;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    stall_now = 1'b0;
    if (hold_left > 0) begin
      stall_now = 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      stall_now = 1'b1;
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < stall_pct) begin
        stall_now  = 1'b1;
        burst_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
      end
    end
    out_stall <= stall_now;
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("source_lexer: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= gap_pct) return 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // one byte request; returns at the edge that accepts it
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_source_char <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_byte(c);
    bytes_sent++;
  endtask

  // both start registers; only called while the block is idle
  task automatic load_start(input logic [15:0] line, input logic [15:0] col);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_START_LINE;
    cfg_wdata <= line;
    @(posedge clk);
    base_line = line;
    cfg_index <= REG_START_COLUMN;
    cfg_wdata <= col;
    @(posedge clk);
    base_col = col;
    cfg_wr_en <= 1'b0;
  endtask

  // drop valid, wait for every expected token, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- random sources
  function automatic logic [7:0] letter_char();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(r) + "a";
    if (r < 52) return 8'(r - 26) + "A";
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'($urandom_range(0, 9)) + "0";
  endfunction

  function automatic logic [7:0] word_char();
    return ($urandom_range(0, 3) == 0) ? digit_char() : letter_char();
  endfunction

  task automatic send_random_token();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      // symbol, often the keyword or a near miss
      k = $urandom_range(0, 9);
      if (k == 0) begin
        send_byte(CH_F);
        send_byte(CH_N);
      end else if (k == 1) begin
        send_byte(CH_F);
      end else if (k == 2) begin
        send_byte(CH_F);
        send_byte(CH_N);
        send_byte(word_char());
      end else begin
        send_byte(letter_char());
        repeat ($urandom_range(0, 5)) send_byte(word_char());
      end
    end else if (r < 35) begin
      // number, dots anywhere
      send_byte(($urandom_range(0, 4) == 0) ? CH_DOT : digit_char());
      repeat ($urandom_range(0, 5))
        send_byte(($urandom_range(0, 4) == 0) ? CH_DOT : digit_char());
    end else if (r < 55) begin
      k = $urandom_range(0, OP_COUNT - 1);
      send_byte(op_char(k));
      if ($urandom_range(0, 1)) send_byte(op_follow(k));
    end else if (r < 67) begin
      send_byte(delim_char($urandom_range(0, DELIM_SUB_MAX)));
    end else if (r < 84) begin
      k = $urandom_range(0, 2);
      send_byte((k == 0) ? CH_SPACE : (k == 1) ? CH_TAB : CH_LF);
    end else if (r < 95) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(($urandom_range(0, 1) == 0) ? CH_CR : 8'($urandom_range(128, 255)));
    end
  endtask

  // a source of random tokens, usually closed by an end-of-source byte
  task automatic send_random_source(input int max_len);
    int len;
    int first;
    len   = $urandom_range(1, max_len);
    first = bytes_sent;
    while (bytes_sent - first < len) send_random_token();
    if ($urandom_range(0, 9) != 0) send_byte(CH_NUL);
    if ($urandom_range(0, 29) == 0) send_byte(CH_NUL);
  endtask

  // ---------------------------------------------------------------- tests
  // keyword, symbols, floats with many dots, operators cut off, bad bytes
  task automatic test_directed();
    logic [7:0] text[$];
    gap_pct   = 20;
    stall_pct = 20;
    load_start(16'd0, 16'd0);
    text = '{"f", "n", CH_SPACE, "f", "n", "9", CH_SPACE, "1", CH_DOT, CH_DOT, "2",
             "+", CH_EQ, "-", "(", CH_CR, 8'hFF, CH_TAB, CH_LF, CH_AMP, CH_AMP, CH_BAR,
             8'h80, CH_DOT, "7", CH_NUL, "<", CH_NUL};
    foreach (text[i]) send_byte(text[i]);
  endtask

  // line and column held at their maximum
  task automatic test_position_saturation();
    logic [7:0] text[$];
    wait_idle();
    load_start(16'hFFFF, 16'hFFFE);
    text = '{"a", "b", CH_SPACE, "(", CH_LF, CH_EQ, CH_NUL};
    foreach (text[i]) send_byte(text[i]);
    wait_idle();
    load_start(16'd0, 16'hFFFF);
    text = '{"1", CH_DOT, "x", 8'h7F, CH_NUL};
    foreach (text[i]) send_byte(text[i]);
  endtask

  // random sources under several start positions and idling profiles
  task automatic test_random_sources();
    int first;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          load_start(16'd0, 16'd0);
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          load_start(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 200)));
          gap_pct   = 20;
          stall_pct = 20;
        end
        2: begin
          load_start(16'hFFFF, 16'hFFFF);
          gap_pct   = 30;
          stall_pct = 40;
        end
        3: begin
          load_start(16'd1, 16'd65500);
          gap_pct   = 10;
          stall_pct = 60;
        end
        4: begin
          load_start(16'($urandom()), 16'($urandom_range(0, 50)));
          gap_pct   = 50;
          stall_pct = 10;
        end
        default: begin
          load_start(16'($urandom()), 16'($urandom()));
          gap_pct   = 5;
          stall_pct = 5;
        end
      endcase
      first = bytes_sent;
      while (bytes_sent - first < PHASE_ITEMS) send_random_source(30);
    end
  endtask

  // result side holds off while bytes keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    load_start(16'd3, 16'd7);
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 120;
    repeat (20) begin
      send_byte(letter_char());
      send_byte(delim_char($urandom_range(0, DELIM_SUB_MAX)));
    end
    send_byte(CH_NUL);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_source_char <= '0;
    out_stall      <= 1'b0;
    base_line = '0;
    base_col  = '0;
    cur_line  = '0;
    cur_col   = '0;
    clear_lexer_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_position_saturation();
    test_random_sources();
    test_backpressure();
    wait_idle();

    if (n_errors == 0 && expected_tokens.size() == 0) begin
      $display("source_lexer: match");
    end else begin
      $display("source_lexer: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/srclx_pkg.sv
design/source_lexer.sv
design/srclx_chk.sv
dv/tb_top.sv
